>>> hdl/btlv_pkg.sv
package btlv_pkg;

   // Event kinds carried on rsp_tuser
   localparam int unsigned KIND_WIDTH = 2;
   localparam logic [KIND_WIDTH-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_VALUE  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_EOC    = 2'd2;

   // Identifier and length octet fields
   localparam logic [7:0] OCTET_CONSTRUCTED = 8'h20;
   localparam logic [7:0] OCTET_TAG_LOW     = 8'h1f;
   localparam logic [7:0] OCTET_MORE        = 8'h80;
   localparam logic [7:0] OCTET_LOW7        = 8'h7f;

   localparam int unsigned LEN_COUNT_WIDTH = 7;

endpackage

>>> hdl/ber_tlv_header_parser.sv
// BER TLV header parser. Takes one octet of a BER stream per cycle on req_
// while req_tready is high and reports one event per complete header (kind
// header, or end of contents for tag 0, primitive, definite length 0) and one
// value event per content octet of a primitive, the final one with rsp_tlast
// high. Every accepted octet is decoded in the cycle it arrives by the
// tag/length state registers, so the sustained rate is one octet per clock.
// Events go to an output register backed by one skid entry; req_tready drops
// only while both hold an event, so a stalled result costs no input cycle
// until the skid entry fills. Extended tag numbers wrap in TAG_WIDTH bits;
// long-form lengths keep the low LENGTH_WIDTH bits. Nesting is not tracked.
module ber_tlv_header_parser
   import btlv_pkg::*;
#(
   parameter int unsigned TAG_WIDTH    = 14,
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // data_byte[7:0]

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // tag_number, constructed, indefinite, length, value_byte, zero pad
   output logic [((TAG_WIDTH + LENGTH_WIDTH + 10 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [KIND_WIDTH-1:0] rsp_tuser,  // kind
   output logic       rsp_tlast      // last_of_value
);

   localparam int unsigned FIELD_BITS = TAG_WIDTH + LENGTH_WIDTH + 10;
   localparam int unsigned DATA_W     = ((FIELD_BITS + 7) / 8) * 8;
   localparam int unsigned PAD_W      = DATA_W - FIELD_BITS;
   localparam int unsigned EVENT_W    = KIND_WIDTH + DATA_W + 1;

   localparam logic [2:0] PH_TAG_FIRST = 3'd0;
   localparam logic [2:0] PH_TAG_EXT   = 3'd1;
   localparam logic [2:0] PH_LEN_FIRST = 3'd2;
   localparam logic [2:0] PH_LEN_LONG  = 3'd3;
   localparam logic [2:0] PH_VALUE     = 3'd4;

   logic [2:0]                 phase_ff, phase_in;
   logic [TAG_WIDTH-1:0]       tag_ff, tag_in;
   logic                       cons_ff, cons_in;
   logic [LENGTH_WIDTH-1:0]    len_ff, len_in;
   logic [LEN_COUNT_WIDTH-1:0] len_left_ff, len_left_in;
   logic [LENGTH_WIDTH-1:0]    val_left_ff, val_left_in;

   logic                    accept;
   logic                    push;
   logic [KIND_WIDTH-1:0]   ev_kind;
   logic                    ev_indef;
   logic [LENGTH_WIDTH-1:0] ev_len;
   logic [7:0]              ev_byte;
   logic                    ev_last;
   logic [EVENT_W-1:0]      ev_word;

   logic [TAG_WIDTH+6:0]    tag_shift;
   logic [LENGTH_WIDTH+7:0] len_shift;
   logic [LENGTH_WIDTH-1:0] fin_len;
   logic [LEN_COUNT_WIDTH-1:0] len_left_dec;
   logic [LENGTH_WIDTH-1:0] val_left_dec;

   logic               out_valid_ff, out_valid_in;
   logic [EVENT_W-1:0] out_word_ff, out_word_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [EVENT_W-1:0] skid_word_ff, skid_word_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign tag_shift    = {tag_ff, req_tdata[6:0]};
   assign len_shift    = {len_ff, req_tdata};
   assign len_left_dec = (len_left_ff != '0) ? len_left_ff - 1'b1 : len_left_ff;
   assign val_left_dec = (val_left_ff != '0) ? val_left_ff - 1'b1 : val_left_ff;

   always_comb begin
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      cons_in     = cons_ff;
      len_in      = len_ff;
      len_left_in = len_left_ff;
      val_left_in = val_left_ff;
      push        = 1'b0;
      ev_kind     = KIND_HEADER;
      ev_indef    = 1'b0;
      ev_byte     = '0;
      ev_last     = 1'b0;
      fin_len     = '0;

      unique case (phase_ff)
         PH_TAG_FIRST: begin
            cons_in = (req_tdata & OCTET_CONSTRUCTED) != '0;
            if ((req_tdata & OCTET_TAG_LOW) == OCTET_TAG_LOW) begin
               tag_in   = '0;
               phase_in = PH_TAG_EXT;
            end else begin
               tag_in   = TAG_WIDTH'(req_tdata & OCTET_TAG_LOW);
               phase_in = PH_LEN_FIRST;
            end
         end
         PH_TAG_EXT: begin
            tag_in = tag_shift[TAG_WIDTH-1:0];
            if ((req_tdata & OCTET_MORE) == '0) begin
               phase_in = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (req_tdata == OCTET_MORE) begin
               push     = 1'b1;
               ev_indef = 1'b1;
               phase_in = PH_TAG_FIRST;
            end else if ((req_tdata & OCTET_MORE) == '0) begin
               push    = 1'b1;
               fin_len = LENGTH_WIDTH'(req_tdata);
            end else begin
               len_in      = '0;
               len_left_in = req_tdata[LEN_COUNT_WIDTH-1:0];
               phase_in    = PH_LEN_LONG;
            end
         end
         PH_LEN_LONG: begin
            len_in      = len_shift[LENGTH_WIDTH-1:0];
            len_left_in = len_left_dec;
            if (len_left_dec == '0) begin
               push    = 1'b1;
               fin_len = len_shift[LENGTH_WIDTH-1:0];
            end
         end
         PH_VALUE: begin
            push        = 1'b1;
            ev_kind     = KIND_VALUE;
            ev_byte     = req_tdata;
            ev_last     = val_left_ff <= LENGTH_WIDTH'(1);
            val_left_in = val_left_dec;
            if (val_left_dec == '0) begin
               phase_in = PH_TAG_FIRST;
            end
         end
         default: begin
            phase_in = PH_TAG_FIRST;
         end
      endcase

      // Close a definite-length header
      if (push && !ev_indef && ev_kind == KIND_HEADER) begin
         if (tag_ff == '0 && !cons_ff && fin_len == '0) begin
            ev_kind  = KIND_EOC;
            phase_in = PH_TAG_FIRST;
         end else if (!cons_ff && fin_len != '0) begin
            val_left_in = fin_len;
            phase_in    = PH_VALUE;
         end else begin
            phase_in = PH_TAG_FIRST;
         end
      end
   end

   assign ev_len = fin_len;

   always_comb begin
      if (ev_kind == KIND_HEADER) begin
         ev_word = {ev_kind, {PAD_W{1'b0}}, 8'h00, ev_len, ev_indef, cons_ff, tag_ff, 1'b0};
      end else if (ev_kind == KIND_VALUE) begin
         ev_word = {ev_kind, {PAD_W{1'b0}}, ev_byte,
                    {(LENGTH_WIDTH + TAG_WIDTH + 2){1'b0}}, ev_last};
      end else begin
         ev_word = {ev_kind, {(DATA_W + 1){1'b0}}};
      end
   end

   // Output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_valid_ff && rsp_tready) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && push;
            out_word_in  = ev_word;
         end
      end else if (accept && push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_word_in  = ev_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = ev_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TAG_FIRST;
         tag_ff        <= '0;
         cons_ff       <= 1'b0;
         len_ff        <= '0;
         len_left_ff   <= '0;
         val_left_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            tag_ff      <= tag_in;
            cons_ff     <= cons_in;
            len_ff      <= len_in;
            len_left_ff <= len_left_in;
            val_left_ff <= val_left_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_word_ff[EVENT_W-1 -: KIND_WIDTH];
   assign rsp_tdata  = out_word_ff[DATA_W:1];
   assign rsp_tlast  = out_word_ff[0];

endmodule

>>> hdl/btlv_checker.sv
module btlv_checker
   import btlv_pkg::*;
#(
   parameter int unsigned TAG_WIDTH    = 14,
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [((TAG_WIDTH + LENGTH_WIDTH + 10 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic [KIND_WIDTH-1:0] rsp_tuser,
   input logic       rsp_tlast
);

   localparam int unsigned HDR_BITS = TAG_WIDTH + LENGTH_WIDTH + 2;

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata != 8'h00 || req_tdata == 8'h00);

   // Hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_value_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_VALUE |-> rsp_tdata[HDR_BITS-1:0] == '0)
      else $error("value event carries header fields");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_VALUE |-> !rsp_tlast && rsp_tdata[HDR_BITS +: 8] == '0)
      else $error("header event carries value fields");

   a_eoc_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EOC |-> rsp_tdata == '0)
      else $error("end of contents event not empty");

   // No response may appear out of reset without a request
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) && !$past(req_seen) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind ber_tlv_header_parser btlv_checker #(
   .TAG_WIDTH    (TAG_WIDTH),
   .LENGTH_WIDTH (LENGTH_WIDTH)
) u_btlv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sv/tb_ber_tlv_header_parser.sv
`timescale 1ns / 100ps
module tb_ber_tlv_header_parser
   import btlv_pkg::*;
();

   localparam int unsigned TAG_W           = 14;
   localparam int unsigned LEN_W           = 32;
   localparam int unsigned DATA_W          = ((TAG_W + LEN_W + 10 + 7) / 8) * 8;
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned TAIL_CYCLES     = 20;
   localparam int unsigned OCTETS_PER_PASS = 180;

   typedef enum logic [2:0] {
      ST_TAG_FIRST,
      ST_TAG_EXT,
      ST_LEN_FIRST,
      ST_LEN_LONG,
      ST_VALUE
   } parse_state_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [TAG_W-1:0]      tag_number;
      logic                  constructed;
      logic                  indefinite;
      logic [LEN_W-1:0]      length;
      logic [7:0]            value_byte;
      logic                  last_of_value;
   } ber_event_type;

   // typed = 1: evt is the event this octet must produce
   typedef struct packed {
      logic [7:0]    octet;
      logic          typed;
      ber_event_type evt;
   } octet_row_type;

   localparam ber_event_type NO_EVENT = '0;

   localparam octet_row_type DIRECTED [27] = '{
      // end of contents in short form
      '{8'h00, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, '{KIND_EOC, 14'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0}},
      // one-octet primitive
      '{8'h02, 1'b0, NO_EVENT},
      '{8'h01, 1'b1, '{KIND_HEADER, 14'd2, 1'b0, 1'b0, 32'd1, 8'd0, 1'b0}},
      '{8'hff, 1'b1, '{KIND_VALUE, 14'd0, 1'b0, 1'b0, 32'd0, 8'hff, 1'b1}},
      // indefinite constructor
      '{8'h30, 1'b0, NO_EVENT},
      '{8'h80, 1'b1, '{KIND_HEADER, 14'd16, 1'b1, 1'b1, 32'd0, 8'd0, 1'b0}},
      // tag 0 primitive, indefinite: a header, not end of contents
      '{8'h00, 1'b0, NO_EVENT},
      '{8'h80, 1'b1, '{KIND_HEADER, 14'd0, 1'b0, 1'b1, 32'd0, 8'd0, 1'b0}},
      // extended tag that wraps past the tag width
      '{8'h1f, 1'b0, NO_EVENT},
      '{8'hff, 1'b0, NO_EVENT},
      '{8'hff, 1'b0, NO_EVENT},
      '{8'hff, 1'b0, NO_EVENT},
      '{8'h7f, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, NO_EVENT},
      // five length octets, only the low 32 bits survive
      '{8'h20, 1'b0, NO_EVENT},
      '{8'h85, 1'b0, NO_EVENT},
      '{8'h01, 1'b0, NO_EVENT},
      '{8'h02, 1'b0, NO_EVENT},
      '{8'h03, 1'b0, NO_EVENT},
      '{8'h04, 1'b0, NO_EVENT},
      '{8'h05, 1'b1, '{KIND_HEADER, 14'd0, 1'b1, 1'b0, 32'h02030405, 8'd0, 1'b0}},
      // end of contents with a long-form zero length
      '{8'h00, 1'b0, NO_EVENT},
      '{8'h81, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, '{KIND_EOC, 14'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0}},
      // empty primitive with a nonzero tag
      '{8'h04, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, '{KIND_HEADER, 14'd4, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0}}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [DATA_W-1:0] rsp_tdata;
   logic [KIND_WIDTH-1:0] rsp_tuser;
   logic              rsp_tlast;

   // decoder state mirrored from the block
   parse_state_type parse_state;
   logic [TAG_W-1:0] tag_acc;
   logic            cons_flag;
   logic [LEN_W-1:0] len_acc;
   logic [LEN_COUNT_WIDTH-1:0] len_octets_left;
   logic [LEN_W-1:0] value_left;

   ber_event_type  pending_events [$];
   octet_row_type  octet_notes [$];
   logic [7:0]  tlv_octets [$];
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   ber_tlv_header_parser #(
      .TAG_WIDTH    (TAG_W),
      .LENGTH_WIDTH (LEN_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Close a definite-length header: end of contents or header event.
   function automatic ber_event_type close_definite(input logic [LEN_W-1:0] len);
      ber_event_type evt;
      evt = '0;
      parse_state = ST_TAG_FIRST;
      if (tag_acc == '0 && !cons_flag && len == '0) begin
         evt.kind = KIND_EOC;
      end else begin
         evt.kind = KIND_HEADER;
         evt.tag_number = tag_acc;
         evt.constructed = cons_flag;
         evt.length = len;
         if (!cons_flag && len != '0) begin
            value_left = len;
            parse_state = ST_VALUE;
         end
      end
      return evt;
   endfunction

   // Advance the decoder by one octet; returns 1 when the octet yields an event.
   function automatic bit ber_decode_octet(input logic [7:0] b, output ber_event_type evt);
      evt = '0;
      case (parse_state)
         ST_TAG_FIRST: begin
            cons_flag = (b & OCTET_CONSTRUCTED) != 0;
            if ((b & OCTET_TAG_LOW) == OCTET_TAG_LOW) begin
               tag_acc = '0;
               parse_state = ST_TAG_EXT;
            end else begin
               tag_acc = TAG_W'(b & OCTET_TAG_LOW);
               parse_state = ST_LEN_FIRST;
            end
            return 1'b0;
         end
         ST_TAG_EXT: begin
            tag_acc = {tag_acc[TAG_W-8:0], b[6:0]};
            if ((b & OCTET_MORE) == 0) parse_state = ST_LEN_FIRST;
            return 1'b0;
         end
         ST_LEN_FIRST: begin
            if (b < OCTET_MORE) begin
               evt = close_definite(LEN_W'(b));
               return 1'b1;
            end
            if (b == OCTET_MORE) begin
               evt.kind = KIND_HEADER;
               evt.tag_number = tag_acc;
               evt.constructed = cons_flag;
               evt.indefinite = 1'b1;
               parse_state = ST_TAG_FIRST;
               return 1'b1;
            end
            len_acc = '0;
            len_octets_left = LEN_COUNT_WIDTH'(b & OCTET_LOW7);
            parse_state = ST_LEN_LONG;
            return 1'b0;
         end
         ST_LEN_LONG: begin
            len_acc = {len_acc[LEN_W-9:0], b};
            if (len_octets_left != 0) len_octets_left--;
            if (len_octets_left == 0) begin
               evt = close_definite(len_acc);
               return 1'b1;
            end
            return 1'b0;
         end
         ST_VALUE: begin
            evt.kind = KIND_VALUE;
            evt.value_byte = b;
            evt.last_of_value = value_left <= 1;
            if (value_left != 0) value_left--;
            if (value_left == 0) parse_state = ST_TAG_FIRST;
            return 1'b1;
         end
         default: begin
            parse_state = ST_TAG_FIRST;
            return 1'b0;
         end
      endcase
   endfunction

   // Append one random TLV (a header, plus content for a primitive) to tlv_octets.
   function automatic void queue_tlv(input bit force_ff);
      logic [7:0]  id;
      logic [7:0]  o;
      logic [31:0] body_word;
      int unsigned pick;
      int unsigned n_ext;
      int unsigned n_len;
      int unsigned body;
      pick = $urandom_range(0, 99);
      if (pick < 8 && !force_ff) begin
         tlv_octets.push_back(8'h00);
         tlv_octets.push_back(8'h00);
         return;
      end
      id = 8'($urandom_range(0, 255));
      if (pick < 35) id = id | OCTET_TAG_LOW;
      tlv_octets.push_back(id);
      if ((id & OCTET_TAG_LOW) == OCTET_TAG_LOW) begin
         n_ext = $urandom_range(1, 5);
         for (int unsigned i = 0; i < n_ext; i++) begin
            o = 8'($urandom_range(0, 255));
            o[7] = (i != n_ext - 1);
            tlv_octets.push_back(o);
         end
      end
      pick = $urandom_range(0, 99);
      if ((id & OCTET_CONSTRUCTED) != 0) begin
         if (force_ff || pick < 4) begin
            tlv_octets.push_back(8'hff);
            for (int i = 0; i < 127; i++) tlv_octets.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 50) begin
            tlv_octets.push_back(8'($urandom_range(0, 127)));
         end else if (pick < 65) begin
            tlv_octets.push_back(OCTET_MORE);
         end else begin
            n_len = $urandom_range(1, 8);
            tlv_octets.push_back(OCTET_MORE | 8'(n_len));
            for (int unsigned i = 0; i < n_len; i++)
               tlv_octets.push_back(8'($urandom_range(0, 255)));
         end
         return;
      end
      // primitive: keep the decoded length small so the content stays short
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      if (pick < 55) begin
         tlv_octets.push_back(8'(body));
      end else if (pick < 63) begin
         tlv_octets.push_back(OCTET_MORE);
         body = 0;
      end else begin
         n_len = (force_ff || pick < 66) ? 127 : $urandom_range(1, 8);
         tlv_octets.push_back(OCTET_MORE | 8'(n_len));
         body_word = body;
         for (int unsigned i = 0; i < n_len; i++) begin
            if (i + 4 >= n_len) tlv_octets.push_back(8'(body_word >> (8 * (n_len - 1 - i))));
            else tlv_octets.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (int unsigned i = 0; i < body; i++) tlv_octets.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic compare_event(input ber_event_type want, input ber_event_type got);
      bit bad;
      bad = 1'b0;
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         bad = 1'b1;
      end
      if (got.tag_number !== want.tag_number) begin
         $error("tag_number: expected %0d, got %0d", want.tag_number, got.tag_number);
         bad = 1'b1;
      end
      if (got.constructed !== want.constructed) begin
         $error("constructed: expected %0d, got %0d", want.constructed, got.constructed);
         bad = 1'b1;
      end
      if (got.indefinite !== want.indefinite) begin
         $error("indefinite: expected %0d, got %0d", want.indefinite, got.indefinite);
         bad = 1'b1;
      end
      if (got.length !== want.length) begin
         $error("length: expected 0x%08h, got 0x%08h", want.length, got.length);
         bad = 1'b1;
      end
      if (got.value_byte !== want.value_byte) begin
         $error("value_byte: expected 0x%02h, got 0x%02h", want.value_byte, got.value_byte);
         bad = 1'b1;
      end
      if (got.last_of_value !== want.last_of_value) begin
         $error("last_of_value: expected %0d, got %0d", want.last_of_value, got.last_of_value);
         bad = 1'b1;
      end
      if (bad) mismatch_count++;
   endtask

   // Predict on every accepted octet, check every accepted event.
   always @(posedge clock) begin
      ber_event_type fresh;
      ber_event_type got;
      octet_row_type note;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            note = octet_notes.pop_front();
            if (ber_decode_octet(req_tdata, fresh))
               pending_events.push_back(note.typed ? note.evt : fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.tag_number = rsp_tdata[TAG_W-1:0];
            got.constructed = rsp_tdata[TAG_W];
            got.indefinite = rsp_tdata[TAG_W+1];
            got.length = rsp_tdata[TAG_W+2 +: LEN_W];
            got.value_byte = rsp_tdata[TAG_W+2+LEN_W +: 8];
            got.last_of_value = rsp_tlast;
            if (pending_events.size() == 0) begin
               $error("unexpected event: kind %0d, tdata 0x%h", rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               compare_event(pending_events.pop_front(), got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   task automatic send_octet(input octet_row_type row);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.octet;
      octet_notes.push_back(row);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering octets and wait until every predicted event has arrived.
   task automatic drain_events();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_events.size() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned sent;
      octet_row_type row;
      parse_state = ST_TAG_FIRST;
      tag_acc = '0;
      cons_flag = 1'b0;
      len_acc = '0;
      len_octets_left = '0;
      value_left = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_octet(DIRECTED[i]);
      drain_events();

      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 7; stall_pct = 7; end
         endcase
         // hold the result side off while octets keep coming
         if (pass == 0) hold_requests++;
         sent = 0;
         while (sent < OCTETS_PER_PASS) begin
            queue_tlv(sent == 0 && (pass == 0 || pass == 2));
            while (tlv_octets.size() != 0) begin
               row = '0;
               row.octet = tlv_octets.pop_front();
               send_octet(row);
               sent++;
            end
         end
         drain_events();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
